>>> hdl/bcds_pkg.sv
// Shared types and constants for the bus clock divider search block.
// Used by the controller, the datapath, the divide unit and the top level.
package bcds_pkg;

    localparam int CLOCK_W        = 32;
    localparam int TARGET_W       = 20;
    localparam int DIVIDER_W      = 8;
    localparam int CODE_W         = 2;
    localparam int DIVIDER_COUNT  = 256;
    localparam int LIMIT_W        = $clog2(DIVIDER_COUNT + 1);
    localparam int QUO_W          = 32;
    localparam int DIV_STEPS_W    = $clog2(QUO_W + 1);

    // Offset added to the divider; a half ratio must exceed it to allow a search.
    localparam logic [LIMIT_W-1:0] DIVIDER_OFFSET = LIMIT_W'(3);
    localparam logic [CODE_W-1:0]  SHIFT_FIRST    = CODE_W'(3);
    localparam logic [CODE_W-1:0]  SHIFT_LAST     = CODE_W'(0);

    // Which quotient the shared divide unit is working on.
    localparam logic DIV_SEL_LIMIT = 1'b0;
    localparam logic DIV_SEL_CAND  = 1'b1;

    typedef struct packed {
        logic load;       // capture a new request and reset the running best
        logic div_start;  // launch the divide unit
        logic div_sel;    // operand selection for the divide unit
        logic set_limit;  // turn the ratio quotient into the search limit
        logic eval;       // compare the candidate quotient against the best
        logic advance;    // step to the next divider and shift pair
        logic publish;    // copy the best result into the output registers
    } bcds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic target_zero;
        logic limit_zero;
        logic last_cand;
    } bcds_status_t;

endpackage

>>> hdl/bcds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bcds_pkg for widths.
module bcds_div
    import bcds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [QUO_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [QUO_W-1:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [DIV_STEPS_W-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [QUO_W:0]         trial;
    logic [QUO_W:0]         diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_STEPS_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - DIV_STEPS_W'(1);
            if (cnt_reg == DIV_STEPS_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/bcds_datapath.sv
// Datapath: request registers, search limit, candidate counters, running best
// and output registers. Depends on bcds_pkg and instantiates bcds_div.
module bcds_datapath
    import bcds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcds_cmd_t            cmd,
    output bcds_status_t         status,
    input  logic [CLOCK_W-1:0]   clock_hz,
    input  logic [TARGET_W-1:0]  target_hz,
    output logic [DIVIDER_W-1:0] divider,
    output logic [CODE_W-1:0]    prescale_code,
    output logic [TARGET_W-1:0]  error_hz,
    output logic                 found
);

    logic [CLOCK_W-1:0]   clock_reg;
    logic [TARGET_W-1:0]  target_reg;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [DIVIDER_W-1:0] d_reg, d_next;
    logic [CODE_W-1:0]    p_reg, p_next;
    logic [TARGET_W-1:0]  best_reg, best_next;
    logic [DIVIDER_W-1:0] best_d_reg, best_d_next;
    logic [CODE_W-1:0]    best_code_reg, best_code_next;
    logic                 found_reg, found_next;
    logic [DIVIDER_W-1:0] divider_reg;
    logic [CODE_W-1:0]    prescale_code_reg;
    logic [TARGET_W-1:0]  error_hz_reg;
    logic                 found_out_reg;

    logic [QUO_W-1:0]     div_dividend;
    logic [QUO_W-1:0]     div_divisor;
    logic [QUO_W-1:0]     quotient;
    logic                 div_done;
    logic [CLOCK_W-1:0]   shifted_clock;
    logic [LIMIT_W-1:0]   d_plus_off;
    logic [QUO_W-2:0]     half;
    logic [QUO_W-2:0]     half_m3;
    logic [QUO_W-1:0]     target_wide;
    logic [QUO_W-1:0]     cand_err;

    // The candidate frequency uses clock >> (p + 2).
    always_comb
    begin
        unique case (p_reg)
            2'd0:    shifted_clock = clock_reg >> 2;
            2'd1:    shifted_clock = clock_reg >> 3;
            2'd2:    shifted_clock = clock_reg >> 4;
            default: shifted_clock = clock_reg >> 5;
        endcase
    end

    assign d_plus_off   = {1'b0, d_reg} + DIVIDER_OFFSET;
    assign div_dividend = (cmd.div_sel == DIV_SEL_LIMIT) ? clock_reg : shifted_clock;
    assign div_divisor  = (cmd.div_sel == DIV_SEL_LIMIT)
                          ? {{(QUO_W-TARGET_W){1'b0}}, target_reg}
                          : {{(QUO_W-LIMIT_W-1){1'b0}}, d_plus_off, 1'b0};

    bcds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign half        = quotient[QUO_W-1:1];
    assign half_m3     = half - (QUO_W-1)'(DIVIDER_OFFSET);
    assign target_wide = {{(QUO_W-TARGET_W){1'b0}}, target_reg};
    assign cand_err    = (quotient >= target_wide) ? (quotient - target_wide)
                                                   : (target_wide - quotient);

    always_comb
    begin
        limit_next     = limit_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        best_next      = best_reg;
        best_d_next    = best_d_reg;
        best_code_next = best_code_reg;
        found_next     = found_reg;
        if (cmd.load)
        begin
            d_next         = '0;
            p_next         = SHIFT_FIRST;
            best_next      = target_hz;
            best_d_next    = '0;
            best_code_next = '0;
            found_next     = 1'b0;
            limit_next     = '0;
        end
        if (cmd.set_limit)
        begin
            if (half <= (QUO_W-1)'(DIVIDER_OFFSET))
                limit_next = '0;
            else if (half_m3 > (QUO_W-1)'(DIVIDER_COUNT))
                limit_next = LIMIT_W'(DIVIDER_COUNT);
            else
                limit_next = half_m3[LIMIT_W-1:0];
        end
        // Only a strictly smaller error wins, so ties keep the earlier candidate.
        if (cmd.eval && (cand_err < {{(QUO_W-TARGET_W){1'b0}}, best_reg}))
        begin
            best_next      = cand_err[TARGET_W-1:0];
            best_d_next    = d_reg;
            best_code_next = ~p_reg;
            found_next     = 1'b1;
        end
        if (cmd.advance)
        begin
            if (p_reg == SHIFT_LAST)
            begin
                p_next = SHIFT_FIRST;
                d_next = d_reg + DIVIDER_W'(1);
            end
            else
            begin
                p_next = p_reg - CODE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clock_reg  <= clock_hz;
            target_reg <= target_hz;
        end
        limit_reg     <= limit_next;
        d_reg         <= d_next;
        p_reg         <= p_next;
        best_reg      <= best_next;
        best_d_reg    <= best_d_next;
        best_code_reg <= best_code_next;
        found_reg     <= found_next;
        if (cmd.publish)
        begin
            divider_reg       <= best_d_reg;
            prescale_code_reg <= best_code_reg;
            error_hz_reg      <= best_reg;
            found_out_reg     <= found_reg;
        end
    end

    assign status.div_done    = div_done;
    assign status.target_zero = (target_reg == '0);
    assign status.limit_zero  = (limit_reg == '0);
    assign status.last_cand   = (p_reg == SHIFT_LAST)
                                && (({1'b0, d_reg} + LIMIT_W'(1)) == limit_reg);

    assign divider       = divider_reg;
    assign prescale_code = prescale_code_reg;
    assign error_hz      = error_hz_reg;
    assign found         = found_out_reg;

endmodule

>>> hdl/bcds_ctrl.sv
// Controller state machine that sequences the limit division and the
// candidate sweep. Depends on bcds_pkg for the command and status structs.
module bcds_ctrl
    import bcds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  bcds_status_t status,
    output bcds_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LDIV  = 3'd1;
    localparam logic [2:0] S_LWAIT = 3'd2;
    localparam logic [2:0] S_LCHK  = 3'd3;
    localparam logic [2:0] S_CDIV  = 3'd4;
    localparam logic [2:0] S_CWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LDIV;
                end
            end
            S_LDIV:
            begin
                if (status.target_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_LIMIT;
                    state_next    = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                cmd.div_sel = DIV_SEL_LIMIT;
                if (status.div_done)
                begin
                    cmd.set_limit = 1'b1;
                    state_next    = S_LCHK;
                end
            end
            S_LCHK:
            begin
                state_next = status.limit_zero ? S_DONE : S_CDIV;
            end
            S_CDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_CAND;
                state_next    = S_CWAIT;
            end
            S_CWAIT:
            begin
                cmd.div_sel = DIV_SEL_CAND;
                if (status.div_done)
                begin
                    cmd.eval = 1'b1;
                    if (status.last_cand)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_CDIV;
                    end
                end
            end
            S_DONE:
            begin
                // Wait for the output register to be free before overwriting it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/bus_clock_divider_search_top.sv
// Bus clock divider search: one request of clock_hz and target_hz yields one
// result of divider, prescale_code, error_hz and found. A request first divides
// clock_hz by target_hz to set the search limit L (at most 256), then tries 4*L
// divider and prescaler candidates, each through the shared 32-step bit-serial
// divider, which sets the pace of the search.
// One request is searched at a time; the finished result sits in an output
// register, so the next request is taken while it waits to be read.
// Depends on bcds_pkg, bcds_ctrl, bcds_datapath and bcds_div.
module bus_clock_divider_search_top
    import bcds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CLOCK_W-1:0]   clock_hz,
    input  logic [TARGET_W-1:0]  target_hz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIVIDER_W-1:0] divider,
    output logic [CODE_W-1:0]    prescale_code,
    output logic [TARGET_W-1:0]  error_hz,
    output logic                 found
);

    bcds_cmd_t    cmd;
    bcds_status_t status;

    bcds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcds_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .clock_hz      (clock_hz),
        .target_hz     (target_hz),
        .divider       (divider),
        .prescale_code (prescale_code),
        .error_hz      (error_hz),
        .found         (found)
    );

endmodule

>>> hdl/bcds_checker.sv
// Port-level checks for the bus clock divider search block, attached by bind.
// Depends on bcds_pkg for field widths.
module bcds_checker
    import bcds_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [CLOCK_W-1:0]   clock_hz,
    input logic [TARGET_W-1:0]  target_hz,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DIVIDER_W-1:0] divider,
    input logic [CODE_W-1:0]    prescale_code,
    input logic [TARGET_W-1:0]  error_hz,
    input logic                 found
);

    // A request is searched alone, so the input closes right after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a request was taken");

    // A waiting request holds its fields until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(clock_hz) && $stable(target_hz)))
    else $error("request changed while waiting");

    // A result that matched nothing reports divider and code as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (divider == '0 && prescale_code == '0))
    else $error("no-match result with nonzero divider or code");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(divider)
            && $stable(prescale_code) && $stable(error_hz) && $stable(found)))
    else $error("result changed while stalled");

endmodule

bind bus_clock_divider_search_top bcds_checker u_bcds_checker (.*);
